// ----- sv/cnpj_pkg.sv -----
// Shared types and constants for the company-ID check-digit validator.
package cnpj_pkg;

    localparam int unsigned STORE_DEPTH = 18;
    localparam int unsigned ID_DIGITS   = 14;
    localparam int unsigned MIN_DIGITS  = 3;
    localparam int unsigned COUNT_W     = 5;
    localparam int unsigned STEP_W      = 4;
    localparam int unsigned VALUE_W     = 47;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_TOO_LONG = 2'd1,
        ERR_BAD_CHAR = 2'd2,
        ERR_MISMATCH = 2'd3
    } err_code_t;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_EVAL,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic accept;      // store one input beat
        logic eval_init;   // clear the digit walk accumulators
        logic eval_step;   // process one padded digit position
        logic load_result; // register the result and restart the string
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_step;
    } dp_status_t;

endpackage

// ----- sv/cnpj_ctrl.sv -----
// Controller state machine: collects a string, sequences the digit walk, hands off the result.
module cnpj_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tlast,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output cnpj_pkg::ctrl_cmd_t    cmd,
    input  cnpj_pkg::dp_status_t   status
);
    import cnpj_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        s_tready        = 1'b0;
        out_valid_next  = out_valid_reg && !m_tready;
        case (state_reg)
            ST_COLLECT:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    if (s_tlast)
                    begin
                        cmd.eval_init = 1'b1;
                        state_next    = ST_EVAL;
                    end
                end
            end
            ST_EVAL:
            begin
                cmd.eval_step = 1'b1;
                if (status.last_step)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // The result register frees up in the same cycle its beat is taken.
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ----- sv/cnpj_datapath.sv -----
// Datapath: character store, count, digit walk with mod-11 accumulators and result register.
module cnpj_datapath
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             char_in,
    input  cnpj_pkg::ctrl_cmd_t    cmd,
    output cnpj_pkg::dp_status_t   status,
    output logic                   id_valid,
    output logic [46:0]            id_value,
    output logic [1:0]             error_code
);
    import cnpj_pkg::*;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] DEPTH_C   = COUNT_W'(STORE_DEPTH);
    localparam logic [COUNT_W-1:0] DIGITS_C  = COUNT_W'(ID_DIGITS);
    localparam logic [COUNT_W-1:0] MIN_C     = COUNT_W'(MIN_DIGITS);
    localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(ID_DIGITS - 1);

    // Digit positions inside the masked form NN.NNN.NNN/NNNN-NN.
    localparam logic [COUNT_W-1:0] MASKED_POS [ID_DIGITS] = '{
        5'd0, 5'd1, 5'd3, 5'd4, 5'd5, 5'd7, 5'd8,
        5'd9, 5'd11, 5'd12, 5'd13, 5'd14, 5'd16, 5'd17
    };

    // Remainder by eleven of a value below 128, through a reciprocal multiply.
    function automatic logic [3:0] mod11(input logic [6:0] x);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  r;
        prod = x * 8'd187;
        q    = prod[14:11];
        r    = x - 7'(q) * 7'd11;
        return r[3:0];
    endfunction

    logic [7:0]          store [STORE_DEPTH];
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [3:0]          sum1_reg, sum1_next;
    logic [3:0]          sum2_reg, sum2_next;
    logic [3:0]          d12_reg, d12_next;
    logic [3:0]          d13_reg, d13_next;
    logic                bad_reg, bad_next;
    logic [VALUE_W-1:0]  value_reg, value_next;

    logic                res_valid_reg;
    logic [VALUE_W-1:0]  res_value_reg;
    err_code_t           res_err_reg;

    logic                masked;
    logic                too_long;
    logic [COUNT_W-1:0]  pad_sum;
    logic [COUNT_W-1:0]  src_raw;
    logic [COUNT_W-1:0]  src_idx;
    logic                present;
    logic [7:0]          ch;
    logic                is_digit;
    logic [7:0]          ch_off;
    logic [3:0]          digit;
    logic [3:0]          w1, w2;
    logic [7:0]          p1, p2;
    logic [3:0]          cd1, cd2;
    err_code_t           err;

    always_ff @(posedge clk)
    begin
        if (cmd.accept && (count_reg < DEPTH_C))
        begin
            store[count_reg] <= char_in;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.load_result)
        begin
            count_next = '0;
        end
        else if (cmd.accept && (count_reg != COUNT_MAX))
        begin
            count_next = count_reg + 1'b1;
        end
    end

    assign masked   = (count_reg == DEPTH_C) && (store[2] == CH_DOT) && (store[6] == CH_DOT)
                      && (store[10] == CH_SLASH) && (store[15] == CH_DASH);
    assign too_long = (count_reg > DEPTH_C) || (!masked && (count_reg > DIGITS_C));

    // Plain strings are right aligned: position i holds character i + n - 14.
    assign pad_sum  = COUNT_W'(step_reg) + count_reg;
    assign src_raw  = masked ? MASKED_POS[step_reg] : (pad_sum - DIGITS_C);
    assign present  = masked || (pad_sum >= DIGITS_C);
    assign src_idx  = (src_raw < DEPTH_C) ? src_raw : '0;
    assign ch       = store[src_idx];
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign ch_off   = ch - CH_ZERO;
    assign digit    = (present && is_digit) ? ch_off[3:0] : 4'd0;

    assign w1 = (step_reg > 4'd3) ? (4'd13 - step_reg) : (4'd5 - step_reg);
    assign w2 = (step_reg > 4'd4) ? (4'd14 - step_reg) : (4'd6 - step_reg);
    assign p1 = (step_reg < 4'd12) ? (w1 * digit) : 8'd0;
    assign p2 = (step_reg < 4'd13) ? (w2 * digit) : 8'd0;

    always_comb
    begin
        step_next  = step_reg;
        sum1_next  = sum1_reg;
        sum2_next  = sum2_reg;
        d12_next   = d12_reg;
        d13_next   = d13_reg;
        bad_next   = bad_reg;
        value_next = value_reg;
        if (cmd.eval_init)
        begin
            step_next  = '0;
            sum1_next  = '0;
            sum2_next  = '0;
            bad_next   = 1'b0;
            value_next = '0;
        end
        else if (cmd.eval_step)
        begin
            step_next  = step_reg + 1'b1;
            sum1_next  = mod11(7'(sum1_reg) + p1[6:0]);
            sum2_next  = mod11(7'(sum2_reg) + p2[6:0]);
            bad_next   = bad_reg || (present && !is_digit);
            value_next = (value_reg << 3) + (value_reg << 1) + VALUE_W'(digit);
            if (step_reg == 4'd12)
            begin
                d12_next = digit;
            end
            if (step_reg == STEP_LAST)
            begin
                d13_next = digit;
            end
        end
    end

    assign status.last_step = (step_reg == STEP_LAST);

    assign cd1 = (sum1_reg < 4'd2) ? 4'd0 : (4'd11 - sum1_reg);
    assign cd2 = (sum2_reg < 4'd2) ? 4'd0 : (4'd11 - sum2_reg);

    always_comb
    begin
        if (too_long)
        begin
            err = ERR_TOO_LONG;
        end
        else if (bad_reg || (!masked && (count_reg < MIN_C)))
        begin
            err = ERR_BAD_CHAR;
        end
        else if ((cd1 != d12_reg) || (cd2 != d13_reg))
        begin
            err = ERR_MISMATCH;
        end
        else
        begin
            err = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum1_reg  <= sum1_next;
        sum2_reg  <= sum2_next;
        d12_reg   <= d12_next;
        d13_reg   <= d13_next;
        bad_reg   <= bad_next;
        value_reg <= value_next;
        if (cmd.load_result)
        begin
            res_valid_reg <= (err == ERR_NONE);
            res_value_reg <= (err == ERR_NONE) ? value_reg : '0;
            res_err_reg   <= err;
        end
    end

    assign id_valid   = res_valid_reg;
    assign id_value   = res_value_reg;
    assign error_code = res_err_reg;

endmodule

// ----- sv/cnpj_text_check_digit_validator.sv -----
// Top level of the company-ID text check-digit validator.
//
// Characters of one ID string arrive as input beats, one per cycle, the final one marked by
// s_tlast. The string is either the 18-character masked form NN.NNN.NNN/NNNN-NN or up to 14
// plain digits with leading zeros left out. After the final beat the block stops taking input,
// walks the 14 padded digit positions one per cycle through a single shared step unit that
// accumulates both weighted mod-11 sums and the binary value, then forms the result in the
// finish state, which waits while an earlier result in the output register is not yet taken.
// Input is taken again as soon as the result sits in the output register, before it is taken.
// Error codes: 0 ok, 1 too long, 2 bad character or too short, 3 check digit mismatch; the
// value reads zero unless the ID is valid.
module cnpj_text_check_digit_validator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,   // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // [0] id_valid, [47:1] id_value, [49:48] error_code, zeros
);
    import cnpj_pkg::*;

    ctrl_cmd_t          cmd;
    dp_status_t         status;
    logic               id_valid;
    logic [VALUE_W-1:0] id_value;
    logic [1:0]         error_code;

    cnpj_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    cnpj_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (s_tdata),
        .cmd        (cmd),
        .status     (status),
        .id_valid   (id_valid),
        .id_value   (id_value),
        .error_code (error_code)
    );

    assign m_tdata = {6'd0, error_code, id_value, id_valid};

endmodule
